// ----- hw/rtl/ntp_pkg.sv -----
package ntp_pkg;

  localparam logic [13:0] OCT_STEPS   = 14'd1536;
  localparam logic [15:0] UNITY_PITCH = 16'h1000;
  localparam logic [15:0] STEP_FACTOR = 16'h103B;
  localparam logic [13:0] PITCH_SAT   = 14'h3FFF;
  localparam logic [18:0] PITCH_LIMIT = 19'h4000;

  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic        valid;
    logic [13:0] pitch;
  } ntp_res_t;

endpackage

// ----- hw/rtl/ntp_mul.sv -----
module ntp_mul (
  input  logic [ntp_pkg::MUL_A_W-1:0] mul_a,
  input  logic [ntp_pkg::MUL_B_W-1:0] mul_b,
  output logic [ntp_pkg::MUL_P_W-1:0] mul_p
);

  // shared unsigned multiplier, product is registered by the sequencer
  assign mul_p = {{ntp_pkg::MUL_B_W{1'b0}}, mul_a} * {{ntp_pkg::MUL_A_W{1'b0}}, mul_b};

endmodule

// ----- hw/rtl/ntp_ctrl.sv -----
module ntp_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [6:0]                  center_note,
  input  logic [6:0]                  center_fine,
  input  logic [6:0]                  target_note,
  input  logic [6:0]                  target_fine,
  output logic [ntp_pkg::MUL_A_W-1:0] mul_a,
  output logic [ntp_pkg::MUL_B_W-1:0] mul_b,
  input  logic [ntp_pkg::MUL_P_W-1:0] mul_p,
  output ntp_pkg::ntp_res_t           res,
  input  logic                        res_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_LO,
    S_HI,
    S_FRAC
  } state_t;

  state_t      state_r, state_nxt;
  logic        down_r, down_nxt;
  logic [13:0] mag_r, mag_nxt;
  logic [3:0]  oct_r, oct_nxt;
  logic [15:0] base_r, base_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [4:0]  frac_r, frac_nxt;
  logic [13:0] mult_r, mult_nxt;
  logic [13:0] hm_r, hm_nxt;
  logic [29:0] lo_r, lo_nxt;
  logic [17:0] d_r, d_nxt;

  always_comb begin
    logic [13:0] center;
    logic [13:0] target;
    logic [13:0] rem;
    logic [3:0]  oct_a;
    logic [29:0] diff;
    logic [30:0] sum;

    state_nxt = state_r;
    down_nxt  = down_r;
    mag_nxt   = mag_r;
    oct_nxt   = oct_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    frac_nxt  = frac_r;
    mult_nxt  = mult_r;
    hm_nxt    = hm_r;
    lo_nxt    = lo_r;
    d_nxt     = d_r;
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    res.valid = 1'b0;
    res.pitch = '0;

    center = {center_note, center_fine};
    target = {target_note, target_fine};
    rem    = mag_r;
    oct_a  = oct_r;
    diff   = '0;
    sum    = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          down_nxt  = target < center;
          mag_nxt   = (target < center) ? (center - target) : (target - center);
          oct_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (mag_r >= ntp_pkg::OCT_STEPS) begin
          mag_nxt = mag_r - ntp_pkg::OCT_STEPS;
          oct_nxt = oct_r + 4'd1;
        end else begin
          // downward with remainder: round octave away from zero
          if (down_r && (mag_r != '0)) begin
            rem   = ntp_pkg::OCT_STEPS - mag_r;
            oct_a = oct_r + 4'd1;
          end
          if (down_r) begin
            base_nxt = ntp_pkg::UNITY_PITCH >> oct_a;
          end else if (oct_a < 4'd4) begin
            base_nxt = ntp_pkg::UNITY_PITCH << oct_a[1:0];
          end else begin
            base_nxt = '0;
          end
          oct_nxt   = oct_a;
          cnt_nxt   = rem[10:5];
          frac_nxt  = rem[4:0];
          mult_nxt  = ntp_pkg::UNITY_PITCH[13:0];
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mul_a = {4'b0, mult_r};
        mul_b = ntp_pkg::STEP_FACTOR;
        if (cnt_r != '0) begin
          mult_nxt = mul_p[25:12];
          cnt_nxt  = cnt_r - 6'd1;
        end else begin
          hm_nxt    = mul_p[25:12];
          state_nxt = S_LO;
        end
      end
      S_LO: begin
        mul_a     = {4'b0, mult_r};
        mul_b     = base_r;
        lo_nxt    = mul_p[29:0];
        state_nxt = S_HI;
      end
      S_HI: begin
        mul_a     = {4'b0, hm_r};
        mul_b     = base_r;
        diff      = mul_p[29:0] - lo_r;
        d_nxt     = diff[22:5];
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        mul_a     = d_r;
        mul_b     = {11'b0, frac_r};
        sum       = {1'b0, lo_r} + mul_p[30:0];
        res.valid = 1'b1;
        res.pitch = (sum[30:12] >= ntp_pkg::PITCH_LIMIT) ? ntp_pkg::PITCH_SAT : sum[25:12];
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    down_r <= down_nxt;
    mag_r  <= mag_nxt;
    oct_r  <= oct_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
    frac_r <= frac_nxt;
    mult_r <= mult_nxt;
    hm_r   <= hm_nxt;
    lo_r   <= lo_nxt;
    d_r    <= d_nxt;
  end

endmodule

// ----- hw/rtl/note_to_pitch_converter.sv -----
// note to pitch converter
// input channel in_*: one item holds center note/fine and target note/fine.
// output channel out_*: one item holds the 14-bit pitch, 0x1000 = original rate.
// each input item gives exactly one output item.
// an item first runs an octave split by repeated subtract of 1536, then one
// pass of the shared multiplier per 2^(1/48) step, then three multiplies
// for interpolation and rounding.
// the block takes one item at a time; in_tready is high only while idle.
// a finished result sits in the output register; the next item is accepted
// while it waits, and that item's result is held in the sequencer until the
// output register frees up.
// reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_tvalid.
module note_to_pitch_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // center_note, center_fine, target_note, target_fine, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // pitch, zero pad
);

  logic [ntp_pkg::MUL_A_W-1:0] mul_a;
  logic [ntp_pkg::MUL_B_W-1:0] mul_b;
  logic [ntp_pkg::MUL_P_W-1:0] mul_p;
  ntp_pkg::ntp_res_t           res;
  logic                        res_ready;
  logic                        out_valid_r;
  logic [13:0]                 out_pitch_r;

  ntp_mul u_mul (
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  ntp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .center_note (in_tdata[6:0]),
    .center_fine (in_tdata[13:7]),
    .target_note (in_tdata[20:14]),
    .target_fine (in_tdata[27:21]),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_p       (mul_p),
    .res         (res),
    .res_ready   (res_ready)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid && res_ready) begin
      out_pitch_r <= res.pitch;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, out_pitch_r};

endmodule
